// ----- src/card_deck_shuffle_dealer_macros.svh -----
// Assertion macros used by the card deck shuffle dealer checker.
`ifndef CARD_DECK_SHUFFLE_DEALER_MACROS_SVH
`define CARD_DECK_SHUFFLE_DEALER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdsd assertion failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define CDSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdsd assertion failed in the following cycle");

`endif

// ----- src/cdsd_pkg.sv -----
// Shared types and constants for the card deck shuffle dealer.
package cdsd_pkg;

    localparam int WORD_W         = 16;
    localparam int OP_W           = 2;
    localparam int SUIT_W         = 2;
    localparam int RANK_W         = 4;
    localparam int SUIT_COUNT_DEF = 4;
    localparam int RANK_COUNT_DEF = 13;

    typedef enum logic [OP_W-1:0] {
        OP_RESTART = 2'd0,
        OP_SHUFFLE = 2'd1,
        OP_DEAL    = 2'd2,
        OP_PEEK    = 2'd3
    } op_t;

endpackage

// ----- src/card_deck_shuffle_dealer.sv -----
// Top level of the card deck shuffle dealer: card memory, sequencer and output register.
//
// The input channel (in_valid, in_stall, op, random_word) takes one command
// transaction at a time. The output channel (out_valid, out_stall and the result
// fields) returns exactly one result transaction per command.
// From acceptance to out_valid, a restart, a shuffle step once the shuffle is done
// and a deal or peek on an empty deck go straight to the emit state; a deal or
// peek otherwise reads the card memory and converts the card in the deal state;
// a shuffle step runs the bit-serial modulo unit, then the read and the two
// writes on the single-write-port card memory. A new command is taken in the
// cycle after its predecessor's result is loaded into the output register.
// Reset, like a restart, leaves the deck in suit-major order: a per-entry
// written flag makes every never-written entry read as its own position.
// While the receiver stalls, the result stays in the output register and the
// block finishes its current command, then holds in_stall high until the
// register can take the next result.
module card_deck_shuffle_dealer
    import cdsd_pkg::*;
#(
    parameter int SUIT_COUNT = SUIT_COUNT_DEF,
    parameter int RANK_COUNT = RANK_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   op,
    input  logic [WORD_W-1:0] random_word,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              card_valid,
    output logic [SUIT_W-1:0] suit,
    output logic [RANK_W-1:0] rank,
    output logic              shuffle_done,
    output logic              deck_empty
);

    localparam int DECK    = SUIT_COUNT * RANK_COUNT;
    localparam int IW      = (DECK > 1) ? $clog2(DECK) : 1;
    localparam int SUIT_IW = (SUIT_COUNT > 1) ? $clog2(SUIT_COUNT) : 1;
    localparam logic [IW-1:0] LAST = IW'(DECK - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SWAP_RD,
        ST_SWAP_WR,
        ST_DEAL,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    logic [IW-1:0]     swap_reg;
    logic [IW-1:0]     deal_reg;
    logic              empty_reg;
    logic [DECK-1:0]   written_reg;
    op_t               op_reg;
    logic              res_valid_reg;
    logic [SUIT_W-1:0] res_suit_reg;
    logic [RANK_W-1:0] res_rank_reg;
    logic              out_valid_reg;
    logic              card_valid_reg;
    logic [SUIT_W-1:0] suit_reg;
    logic [RANK_W-1:0] rank_reg;
    logic              shuffle_done_reg;
    logic              deck_empty_reg;

    logic [IW-1:0]     mem [DECK];
    logic [IW-1:0]     rd_a_data_reg;
    logic [IW-1:0]     rd_b_data_reg;
    logic [IW-1:0]     rd_a_addr_reg;
    logic [IW-1:0]     rd_b_addr_reg;
    logic              rd_a_init_reg;
    logic              rd_b_init_reg;

    logic              accept;
    logic              rd_en;
    logic [IW-1:0]     rd_a_addr;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [IW-1:0]     wr_data;
    logic [IW-1:0]     card_a;
    logic [IW-1:0]     card_b;
    logic              mod_start;
    logic              mod_done;
    logic [IW:0]       mod_rem;
    logic [SUIT_IW-1:0] conv_suit;
    logic [RANK_W-1:0] conv_rank;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    assign card_a = rd_a_init_reg ? rd_a_data_reg : rd_a_addr_reg;
    assign card_b = rd_b_init_reg ? rd_b_data_reg : rd_b_addr_reg;

    assign mod_start = accept && (op_t'(op) == OP_SHUFFLE) && (swap_reg != '0);

    always_comb
    begin
        rd_en     = 1'b0;
        rd_a_addr = deal_reg;
        wr_en     = 1'b0;
        wr_addr   = rd_a_addr_reg;
        wr_data   = card_b;
        case (state_reg)
            ST_IDLE:
            begin
                rd_en = accept && (op_t'(op) inside {OP_DEAL, OP_PEEK}) && !empty_reg;
            end
            ST_DIVIDE:
            begin
                rd_en     = mod_done;
                rd_a_addr = IW'(mod_rem);
            end
            ST_SWAP_RD:
            begin
                wr_en = 1'b1;
            end
            ST_SWAP_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = swap_reg;
                wr_data = card_a;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        conv_suit = '0;
        conv_rank = '0;
        for (int s = 0; s < SUIT_COUNT; s++)
        begin
            if (card_a >= IW'(s * RANK_COUNT))
            begin
                conv_suit = SUIT_IW'(s);
                conv_rank = RANK_W'(card_a - IW'(s * RANK_COUNT));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_data_reg <= mem[rd_a_addr];
            rd_b_data_reg <= mem[swap_reg];
            rd_a_init_reg <= written_reg[rd_a_addr];
            rd_b_init_reg <= written_reg[swap_reg];
            rd_a_addr_reg <= rd_a_addr;
            rd_b_addr_reg <= swap_reg;
        end
    end

    cdsd_mod_unit #(
        .DIV_W(IW + 1)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (random_word),
        .divisor  ({1'b0, swap_reg} + 1'b1),
        .done     (mod_done),
        .remainder(mod_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            swap_reg         <= LAST;
            deal_reg         <= '0;
            empty_reg        <= 1'b0;
            written_reg      <= '0;
            op_reg           <= OP_RESTART;
            res_valid_reg    <= 1'b0;
            res_suit_reg     <= '0;
            res_rank_reg     <= '0;
            out_valid_reg    <= 1'b0;
            card_valid_reg   <= 1'b0;
            suit_reg         <= '0;
            rank_reg         <= '0;
            shuffle_done_reg <= 1'b0;
            deck_empty_reg   <= 1'b0;
        end
        else
        begin
            if (!out_stall && (state_reg != ST_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg        <= op_t'(op);
                        res_valid_reg <= 1'b0;
                        res_suit_reg  <= '0;
                        res_rank_reg  <= '0;
                        case (op_t'(op))
                            OP_RESTART:
                            begin
                                swap_reg    <= LAST;
                                deal_reg    <= '0;
                                empty_reg   <= 1'b0;
                                written_reg <= '0;
                                state_reg   <= ST_EMIT;
                            end
                            OP_SHUFFLE:
                            begin
                                state_reg <= (swap_reg != '0) ? ST_DIVIDE : ST_EMIT;
                            end
                            default:
                            begin
                                state_reg <= empty_reg ? ST_EMIT : ST_DEAL;
                            end
                        endcase
                    end
                end
                ST_DIVIDE:
                begin
                    if (mod_done)
                    begin
                        state_reg <= ST_SWAP_RD;
                    end
                end
                ST_SWAP_RD:
                begin
                    written_reg[rd_a_addr_reg] <= 1'b1;
                    state_reg                  <= ST_SWAP_WR;
                end
                ST_SWAP_WR:
                begin
                    written_reg[swap_reg] <= 1'b1;
                    swap_reg              <= swap_reg - 1'b1;
                    state_reg             <= ST_EMIT;
                end
                ST_DEAL:
                begin
                    res_valid_reg <= 1'b1;
                    res_suit_reg  <= SUIT_W'(conv_suit);
                    res_rank_reg  <= conv_rank;
                    if (op_reg == OP_DEAL)
                    begin
                        if (deal_reg == LAST)
                        begin
                            deal_reg  <= '0;
                            empty_reg <= 1'b1;
                        end
                        else
                        begin
                            deal_reg <= deal_reg + 1'b1;
                        end
                    end
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg    <= 1'b1;
                        card_valid_reg   <= res_valid_reg;
                        suit_reg         <= res_suit_reg;
                        rank_reg         <= res_rank_reg;
                        shuffle_done_reg <= (swap_reg == '0);
                        deck_empty_reg   <= empty_reg;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign card_valid   = card_valid_reg;
    assign suit         = suit_reg;
    assign rank         = rank_reg;
    assign shuffle_done = shuffle_done_reg;
    assign deck_empty   = deck_empty_reg;

endmodule

// ----- src/cdsd_mod_unit.sv -----
// Iterative restoring modulo unit, one dividend bit per cycle.
module cdsd_mod_unit
    import cdsd_pkg::*;
#(
    parameter int DIV_W = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] remainder
);

    localparam int CNT_W = $clog2(WORD_W);

    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  rem_next;
    logic [WORD_W-1:0] dvd_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_W:0]    trial;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[WORD_W-1]};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = DIV_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = DIV_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == CNT_W'(WORD_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[WORD_W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- src/cdsd_checker.sv -----
// Port-level checker for the card deck shuffle dealer and its bind statement.
`include "card_deck_shuffle_dealer_macros.svh"

module cdsd_checker
    import cdsd_pkg::*;
#(
    parameter int RANK_COUNT = RANK_COUNT_DEF
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic              card_valid,
    input logic [SUIT_W-1:0] suit,
    input logic [RANK_W-1:0] rank
);

    `CDSD_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && out_stall, out_valid)
    `CDSD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `CDSD_ASSERT_NOW(a_no_card_zero, clk, rst_n, out_valid && !card_valid, (suit == '0) && (rank == '0))
    `CDSD_ASSERT_NOW(a_rank_range, clk, rst_n, out_valid && card_valid, int'(rank) < RANK_COUNT)

endmodule

bind card_deck_shuffle_dealer cdsd_checker #(.RANK_COUNT(RANK_COUNT)) u_cdsd_checker (.*);
